// ----- rtl/core/isbn13_hyphenated_validator_macros.svh -----
// ----------------------------------------------------------------------------
// ISBN-13 validator assertion macros
// Concurrent assertion forms for the validator checker.
// ----------------------------------------------------------------------------
`ifndef ISBN13_HYPHENATED_VALIDATOR_MACROS_SVH
`define ISBN13_HYPHENATED_VALIDATOR_MACROS_SVH

// Check a property outside reset.
`define ISBN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ISBN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/isbn_pkg.sv -----
// ----------------------------------------------------------------------------
// isbn_pkg
// Types and constants shared by the hyphenated ISBN-13 validator.
// ----------------------------------------------------------------------------
package isbn_pkg;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    localparam logic [3:0] DIGIT_TOTAL   = 4'd13;
    localparam logic [3:0] WEIGHTED_LAST = 4'd12;
    localparam logic [3:0] COUNT_SAT     = 4'd14;
    localparam logic [2:0] PREFIX_LEN    = 3'd3;
    localparam logic [2:0] GROUP_SAT     = 3'd4;

    typedef enum logic [2:0] {
        RSN_OK          = 3'd0,
        RSN_BAD_CHAR    = 3'd1,
        RSN_DIGIT_COUNT = 3'd2,
        RSN_EDGE_HYPHEN = 3'd3,
        RSN_BAD_PREFIX  = 3'd4,
        RSN_CHECK_DIGIT = 3'd5
    } reason_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic    is_valid;
        reason_t reason;
    } out_t;

    typedef struct packed {
        logic valid;
        in_t  data;
    } scan_in_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } scan_res_t;

endpackage

// ----- rtl/core/isbn_scan.sv -----
// ----------------------------------------------------------------------------
// isbn_scan
// Running state of the string and the verdict on its last character.
// ----------------------------------------------------------------------------
module isbn_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  isbn_pkg::scan_in_t item,
    output isbn_pkg::scan_res_t result
);
    import isbn_pkg::*;

    logic [3:0] digit_count_reg,   digit_count_next;
    logic [3:0] sum_reg,           sum_next;
    logic       weight3_reg,       weight3_next;
    logic       bad_char_reg,      bad_char_next;
    logic       lead_hyphen_reg,   lead_hyphen_next;
    logic       first_group_reg,   first_group_next;
    logic [2:0] group_len_reg,     group_len_next;
    logic       prefix_good_reg,   prefix_good_next;
    logic       seen_char_reg,     seen_char_next;
    logic [3:0] check_digit_reg,   check_digit_next;

    logic       is_digit;
    logic       is_hyphen;
    logic [3:0] digit;
    logic [5:0] term;
    logic [5:0] sum_raw;
    logic [5:0] sum_red;
    logic [3:0] expect_digit;
    reason_t    reason;

    assign is_digit  = (item.data.char_code >= CHAR_ZERO) && (item.data.char_code <= CHAR_NINE);
    assign is_hyphen = (item.data.char_code == CHAR_HYPHEN);
    assign digit     = item.data.char_code[3:0];
    assign term      = weight3_reg ? ({1'b0, digit, 1'b0} + {2'b00, digit}) : {2'b00, digit};
    assign sum_raw   = {2'b00, sum_reg} + term;

    always_comb
    begin
        priority if (sum_raw >= 6'd30)
            sum_red = sum_raw - 6'd30;
        else if (sum_raw >= 6'd20)
            sum_red = sum_raw - 6'd20;
        else if (sum_raw >= 6'd10)
            sum_red = sum_raw - 6'd10;
        else
            sum_red = sum_raw;
    end

    always_comb
    begin
        digit_count_next = digit_count_reg;
        sum_next         = sum_reg;
        weight3_next     = weight3_reg;
        bad_char_next    = bad_char_reg;
        lead_hyphen_next = lead_hyphen_reg;
        first_group_next = first_group_reg;
        group_len_next   = group_len_reg;
        prefix_good_next = prefix_good_reg;
        seen_char_next   = 1'b1;
        check_digit_next = check_digit_reg;

        if (is_digit)
        begin
            if (digit_count_reg < WEIGHTED_LAST)
            begin
                sum_next     = sum_red[3:0];
                weight3_next = !weight3_reg;
            end
            else if (digit_count_reg == WEIGHTED_LAST)
                check_digit_next = digit;
            if (digit_count_reg < COUNT_SAT)
                digit_count_next = digit_count_reg + 4'd1;
            if (first_group_reg)
            begin
                if (group_len_reg == 3'd0 && digit != 4'd9)
                    prefix_good_next = 1'b0;
                if (group_len_reg == 3'd1 && digit != 4'd7)
                    prefix_good_next = 1'b0;
                if (group_len_reg == 3'd2 && digit != 4'd8 && digit != 4'd9)
                    prefix_good_next = 1'b0;
                if (group_len_reg < GROUP_SAT)
                    group_len_next = group_len_reg + 3'd1;
            end
        end
        else if (is_hyphen)
        begin
            if (!seen_char_reg)
                lead_hyphen_next = 1'b1;
            first_group_next = 1'b0;
        end
        else
            bad_char_next = 1'b1;
    end

    assign expect_digit = (sum_next == 4'd0) ? 4'd0 : (4'd10 - sum_next);

    always_comb
    begin
        priority if (bad_char_next)
            reason = RSN_BAD_CHAR;
        else if (digit_count_next != DIGIT_TOTAL)
            reason = RSN_DIGIT_COUNT;
        else if (lead_hyphen_next || is_hyphen)
            reason = RSN_EDGE_HYPHEN;
        else if (!prefix_good_next || group_len_next != PREFIX_LEN)
            reason = RSN_BAD_PREFIX;
        else if (expect_digit != check_digit_next)
            reason = RSN_CHECK_DIGIT;
        else
            reason = RSN_OK;
    end

    assign result.valid         = item.valid && item.data.last_char;
    assign result.data.is_valid = (reason == RSN_OK);
    assign result.data.reason   = reason;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= '0;
            sum_reg         <= '0;
            weight3_reg     <= 1'b0;
            bad_char_reg    <= 1'b0;
            lead_hyphen_reg <= 1'b0;
            first_group_reg <= 1'b1;
            group_len_reg   <= '0;
            prefix_good_reg <= 1'b1;
            seen_char_reg   <= 1'b0;
            check_digit_reg <= '0;
        end
        else if (item.valid)
        begin
            if (item.data.last_char)
            begin
                digit_count_reg <= '0;
                sum_reg         <= '0;
                weight3_reg     <= 1'b0;
                bad_char_reg    <= 1'b0;
                lead_hyphen_reg <= 1'b0;
                first_group_reg <= 1'b1;
                group_len_reg   <= '0;
                prefix_good_reg <= 1'b1;
                seen_char_reg   <= 1'b0;
                check_digit_reg <= '0;
            end
            else
            begin
                digit_count_reg <= digit_count_next;
                sum_reg         <= sum_next;
                weight3_reg     <= weight3_next;
                bad_char_reg    <= bad_char_next;
                lead_hyphen_reg <= lead_hyphen_next;
                first_group_reg <= first_group_next;
                group_len_reg   <= group_len_next;
                prefix_good_reg <= prefix_good_next;
                seen_char_reg   <= seen_char_next;
                check_digit_reg <= check_digit_next;
            end
        end
    end

endmodule

// ----- rtl/core/isbn_out.sv -----
// ----------------------------------------------------------------------------
// isbn_out
// Result register on the outgoing channel.
// ----------------------------------------------------------------------------
module isbn_out (
    input  logic                clk,
    input  logic                rst_n,
    input  isbn_pkg::scan_res_t load,
    output logic                ready,
    output logic                res_valid,
    output isbn_pkg::out_t      res_data,
    input  logic                res_stall
);
    import isbn_pkg::*;

    logic valid_reg, valid_next;
    out_t data_reg;

    assign ready = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
            valid_next = load.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready && load.valid)
            data_reg <= load.data;
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

// ----- rtl/core/isbn13_hyphenated_validator.sv -----
// ----------------------------------------------------------------------------
// isbn13_hyphenated_validator
// Checks a hyphenated ISBN-13 string fed one character per transfer.
//
//   channel | direction | payload                      | handshake
//   char    | in        | char_code, last_char         | char_valid / char_stall
//   res     | out       | is_valid, reason             | res_valid / res_stall
//
// One character per cycle while char_stall is low; a result passes the input
// register, then the result register, after its last character is accepted.
// Reset clears the valid flags of both registers and the running string state.
// A stalled result holds only characters flagged last; others keep flowing.
// ----------------------------------------------------------------------------
module isbn13_hyphenated_validator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_stall,
    input  isbn_pkg::in_t  char_data,
    output logic           res_valid,
    input  logic           res_stall,
    output isbn_pkg::out_t res_data
);
    import isbn_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    in_t       s1_data_reg;
    logic      out_ready;
    logic      advance;
    logic      load;
    scan_in_t  scan_item;
    scan_res_t scan_result;

    assign advance    = s1_valid_reg && (!s1_data_reg.last_char || out_ready);
    assign char_stall = s1_valid_reg && !advance;
    assign load       = char_valid && !char_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_data_reg <= char_data;
    end

    assign scan_item.valid = advance;
    assign scan_item.data  = s1_data_reg;

    isbn_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (scan_item),
        .result (scan_result)
    );

    isbn_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (scan_result),
        .ready     (out_ready),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_stall (res_stall)
    );

endmodule

// ----- rtl/core/isbn_checker.sv -----
// ----------------------------------------------------------------------------
// isbn_checker
// Port-level checks on the ISBN-13 validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "isbn13_hyphenated_validator_macros.svh"

module isbn_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           char_valid,
    input logic           char_stall,
    input isbn_pkg::in_t  char_data,
    input logic           res_valid,
    input logic           res_stall,
    input isbn_pkg::out_t res_data
);
    import isbn_pkg::*;

    `ISBN_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid, "result dropped while stalled")
    `ISBN_ASSERT(a_res_stable, res_valid && res_stall |=> $stable(res_data), "stalled result changed")
    `ISBN_ASSERT(a_verdict, res_valid |-> (res_data.is_valid == (res_data.reason == RSN_OK)), "valid flag disagrees with reason")
    `ISBN_ASSERT_ALWAYS(a_reset_clear, !rst_n |-> !res_valid && !char_stall, "reset left a transfer pending")

endmodule

bind isbn13_hyphenated_validator isbn_checker u_isbn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
);
